>>> design/fmem_pkg.sv
// ----------------------------------------------------------------------------
// fmem_pkg
// Shared types and constants for the filter membership eviction monitor.
// ----------------------------------------------------------------------------
package fmem_pkg;

  localparam int ID_W                = 64;
  localparam int TAG_W               = 8;
  localparam int CFG_W               = 8;
  localparam int OCC_W               = 8;
  localparam int OUT_CNT_W           = 48;
  localparam int NUM_CTRS            = 8;
  localparam int DEFAULT_FILTER_SIZE = 32;

  // request tags
  localparam logic [TAG_W-1:0] TAG_INSERT = 8'd0;
  localparam logic [TAG_W-1:0] TAG_REMOVE = 8'd1;
  localparam logic [TAG_W-1:0] TAG_SINGLE = 8'd2;

  // event counter slots
  localparam int C_EVICTED  = 0;
  localparam int C_INSERT   = 1;
  localparam int C_REMOVE   = 2;
  localparam int C_SINGLE   = 3;
  localparam int C_REQ      = 4;
  localparam int C_OVERFLOW = 5;
  localparam int C_NOTFOUND = 6;
  localparam int C_DUP      = 7;

  // per-cell control from the sequencer
  typedef struct packed {
    logic cmp;    // compare stored ID against the key
    logic load;   // write the key into this cell
    logic shift;  // take the neighbor's contents (close a hole)
  } cell_ctrl_t;

endpackage

>>> design/fmem_req_if.sv
// ----------------------------------------------------------------------------
// fmem_req_if
// Request channel: valid/ready handshake with one request as payload.
// ----------------------------------------------------------------------------
interface fmem_req_if;
  import fmem_pkg::*;

  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  obj_id;
  logic             tag_present;
  logic [TAG_W-1:0] req_type;
  logic             evicted_valid;
  logic [ID_W-1:0]  victim_id;

  modport source (
    output valid, obj_id, tag_present, req_type, evicted_valid, victim_id,
    input  ready
  );

  modport sink (
    input  valid, obj_id, tag_present, req_type, evicted_valid, victim_id,
    output ready
  );

endinterface

>>> design/fmem_res_if.sv
// ----------------------------------------------------------------------------
// fmem_res_if
// Result channel: valid/ready handshake with hit flag, occupancy and counters.
// ----------------------------------------------------------------------------
interface fmem_res_if;
  import fmem_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 evict_hit;
  logic [OCC_W-1:0]     occupancy;
  logic [OUT_CNT_W-1:0] evict_found;
  logic [OUT_CNT_W-1:0] insert_tags;
  logic [OUT_CNT_W-1:0] remove_tags;
  logic [OUT_CNT_W-1:0] single_touch_tags;
  logic [OUT_CNT_W-1:0] request_total;
  logic [OUT_CNT_W-1:0] overflow_total;
  logic [OUT_CNT_W-1:0] not_found_total;
  logic [OUT_CNT_W-1:0] duplicate_total;

  modport source (
    output valid, evict_hit, occupancy, evict_found, insert_tags,
           remove_tags, single_touch_tags, request_total, overflow_total,
           not_found_total, duplicate_total,
    input  ready
  );

  modport sink (
    input  valid, evict_hit, occupancy, evict_found, insert_tags,
           remove_tags, single_touch_tags, request_total, overflow_total,
           not_found_total, duplicate_total,
    output ready
  );

endinterface

>>> design/fmem_cell.sv
// ----------------------------------------------------------------------------
// fmem_cell
// One slot of the ID set: stored ID, valid bit and a registered key match.
// ----------------------------------------------------------------------------
module fmem_cell
  import fmem_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  cell_ctrl_t      ctrl,
  input  logic [ID_W-1:0] key,
  input  logic [ID_W-1:0] nxt_id,
  input  logic            nxt_valid,
  output logic [ID_W-1:0] id,
  output logic            valid,
  output logic            match
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      match <= ctrl.cmp && valid && (id == key);
      if (ctrl.load) begin
        valid <= 1'b1;
      end else if (ctrl.shift) begin
        valid <= nxt_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      id <= key;
    end else if (ctrl.shift) begin
      id <= nxt_id;
    end
  end

endmodule

>>> design/fmem_ctrs.sv
// ----------------------------------------------------------------------------
// fmem_ctrs
// Bank of saturating event counters, bumped once per request by a mask.
// ----------------------------------------------------------------------------
module fmem_ctrs
  import fmem_pkg::*;
#(
  parameter int COUNTER_WIDTH = 48
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic [NUM_CTRS-1:0]                     inc,
  output logic [NUM_CTRS-1:0][COUNTER_WIDTH-1:0]  cnt
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (en) begin
      for (int k = 0; k < NUM_CTRS; k++) begin
        if (inc[k] && (cnt[k] != '1)) begin
          cnt[k] <= cnt[k] + COUNTER_WIDTH'(1);
        end
      end
    end
  end

endmodule

>>> design/filter_membership_eviction_monitor.sv
// ----------------------------------------------------------------------------
// filter_membership_eviction_monitor
// Bounded ID set kept compacted in a row of cells; tag insert/remove, evicted
// ID lookup and saturating event counters, one result per request.
// ----------------------------------------------------------------------------
// The request passes TAG_CMP, TAG_APPLY, EV_CMP, EV_APPLY, then WRITE_BACK,
// which registers the result once the previous one is taken. One request at
// a time: two compare/apply passes over the cell row (tag, then eviction).
// A new request is accepted while the previous result waits in the output reg.
// Reset (rst, synchronous): set empty, counters zero, size limit 32.
// ----------------------------------------------------------------------------
module filter_membership_eviction_monitor
  import fmem_pkg::*;
#(
  parameter int CAPACITY      = 128,
  parameter int COUNTER_WIDTH = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  fmem_req_if.sink         req,
  fmem_res_if.source       res
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW  = (CW > CFG_W + 1) ? CW : CFG_W + 1;
  localparam int OW  = (CW > OCC_W) ? CW : OCC_W;
  localparam int EW  = (COUNTER_WIDTH > OUT_CNT_W) ? COUNTER_WIDTH : OUT_CNT_W;

  typedef enum logic [2:0] {
    IDLE,
    TAG_CMP,
    TAG_APPLY,
    EV_CMP,
    EV_APPLY,
    WRITE_BACK
  } state_t;

  state_t             state;
  logic [CFG_W-1:0]   size_limit;
  logic [CW-1:0]      count;
  logic [NUM_CTRS-1:0] incs;
  logic               hit;

  // captured request
  logic [ID_W-1:0]    obj;
  logic               has_tag;
  logic [TAG_W-1:0]   tag;
  logic               ev_valid;
  logic [ID_W-1:0]    ev_id;

  // cell row
  logic [CAPACITY:0][ID_W-1:0] id_vec;
  logic [CAPACITY:0]           valid_vec;
  logic [CAPACITY-1:0]         match_vec;
  cell_ctrl_t [CAPACITY-1:0]   ctrl_vec;
  logic [ID_W-1:0]             key;
  logic [IW-1:0]               idx;
  logic                        any_hit;
  logic                        tag_ins;
  logic                        tag_rem;
  logic                        full;
  logic                        load_en;
  logic                        shift_en;
  logic [CFG_W:0]              eff_size;
  logic [NUM_CTRS-1:0]         tag_incs;
  logic [NUM_CTRS-1:0]         ctr_inc;

  logic [NUM_CTRS-1:0][COUNTER_WIDTH-1:0] ctr;
  logic [NUM_CTRS-1:0][EW-1:0]            ctr_ext;
  logic [OW-1:0]                          occ_ext;

  assign req.ready = (state == IDLE);

  assign key = ((state == TAG_CMP) || (state == TAG_APPLY)) ? obj : ev_id;

  assign valid_vec[CAPACITY] = 1'b0;
  assign id_vec[CAPACITY]    = '0;

  // at most one cell matches, so OR-ing the slot numbers gives its index
  always_comb begin
    idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_vec[i]) begin
        idx = idx | IW'(i);
      end
    end
  end

  assign any_hit = |match_vec;
  assign tag_ins = has_tag && (tag == TAG_INSERT);
  assign tag_rem = has_tag && (tag == TAG_REMOVE);

  assign eff_size = (size_limit == '0) ? (CFG_W + 1)'(DEFAULT_FILTER_SIZE)
                                       : {1'b0, size_limit};
  assign full = (LW'(count) >= LW'(eff_size)) || (count >= CW'(CAPACITY));

  assign load_en  = (state == TAG_APPLY) && tag_ins && !any_hit && !full;
  assign shift_en = ((state == TAG_APPLY) && tag_rem && any_hit) ||
                    ((state == EV_APPLY) && ev_valid && any_hit);

  always_comb begin
    tag_incs = '0;
    tag_incs[C_REQ]      = 1'b1;
    tag_incs[C_INSERT]   = tag_ins;
    tag_incs[C_DUP]      = tag_ins && any_hit;
    tag_incs[C_OVERFLOW] = tag_ins && !any_hit && full;
    tag_incs[C_REMOVE]   = tag_rem;
    tag_incs[C_NOTFOUND] = tag_rem && !any_hit;
    tag_incs[C_SINGLE]   = has_tag && (tag == TAG_SINGLE);
  end

  always_comb begin
    ctr_inc = incs;
    ctr_inc[C_EVICTED] = ev_valid && any_hit;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign ctrl_vec[i].cmp   = (state == TAG_CMP) || (state == EV_CMP);
    assign ctrl_vec[i].load  = load_en && (count == CW'(i));
    assign ctrl_vec[i].shift = shift_en && (IW'(i) >= idx);

    fmem_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl_vec[i]),
      .key       (key),
      .nxt_id    (id_vec[i+1]),
      .nxt_valid (valid_vec[i+1]),
      .id        (id_vec[i]),
      .valid     (valid_vec[i]),
      .match     (match_vec[i])
    );
  end

  fmem_ctrs #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_ctrs (
    .clk (clk),
    .rst (rst),
    .en  (state == EV_APPLY),
    .inc (ctr_inc),
    .cnt (ctr)
  );

  always_comb begin
    for (int k = 0; k < NUM_CTRS; k++) begin
      ctr_ext[k] = EW'(ctr[k]);
    end
  end

  assign occ_ext = OW'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      size_limit  <= CFG_W'(DEFAULT_FILTER_SIZE);
      count       <= '0;
      incs        <= '0;
      hit         <= 1'b0;
      res.valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        size_limit <= cfg_wr_data;
      end
      if ((state == WRITE_BACK) && (!res.valid || res.ready)) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (req.valid) begin
            obj      <= req.obj_id;
            has_tag  <= req.tag_present;
            tag      <= req.req_type;
            ev_valid <= req.evicted_valid;
            ev_id    <= req.victim_id;
            state    <= TAG_CMP;
          end
        end
        TAG_CMP: begin
          state <= TAG_APPLY;
        end
        TAG_APPLY: begin
          incs <= tag_incs;
          if (load_en) begin
            count <= count + CW'(1);
          end else if (shift_en) begin
            count <= count - CW'(1);
          end
          state <= EV_CMP;
        end
        EV_CMP: begin
          state <= EV_APPLY;
        end
        EV_APPLY: begin
          hit <= ev_valid && any_hit;
          if (shift_en) begin
            count <= count - CW'(1);
          end
          state <= WRITE_BACK;
        end
        WRITE_BACK: begin
          if (!res.valid || res.ready) begin
            res.evict_hit           <= hit;
            res.occupancy           <= occ_ext[OCC_W-1:0];
            res.evict_found         <= ctr_ext[C_EVICTED][OUT_CNT_W-1:0];
            res.insert_tags         <= ctr_ext[C_INSERT][OUT_CNT_W-1:0];
            res.remove_tags         <= ctr_ext[C_REMOVE][OUT_CNT_W-1:0];
            res.single_touch_tags   <= ctr_ext[C_SINGLE][OUT_CNT_W-1:0];
            res.request_total       <= ctr_ext[C_REQ][OUT_CNT_W-1:0];
            res.overflow_total      <= ctr_ext[C_OVERFLOW][OUT_CNT_W-1:0];
            res.not_found_total     <= ctr_ext[C_NOTFOUND][OUT_CNT_W-1:0];
            res.duplicate_total     <= ctr_ext[C_DUP][OUT_CNT_W-1:0];
            state                   <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // set stays compacted: valid cells are exactly the first count slots
  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec[CAPACITY-1:0]) == int'(count))
    else $error("occupancy does not match valid cells");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("occupancy above capacity");

  // IDs are unique in the set, so a lookup hits at most one cell
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    ((state == TAG_APPLY) || (state == EV_APPLY)) |-> $onehot0(match_vec))
    else $error("more than one cell matched the key");

  a_hit_needs_eviction: assert property (@(posedge clk) disable iff (rst)
    ((state == WRITE_BACK) && hit) |-> ev_valid)
    else $error("eviction hit without a valid eviction");

endmodule
